@@ rtl/core/seven_segment_scan_driver_unit_assert.svh @@
// Assertion macros for the seven-segment scan driver checker.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication, checked at every clock edge out of reset
`define SSSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sssd_pkg.sv @@
// Shared types, constants and segment decode for the seven-segment scan driver.
`timescale 1ns / 1ps

package sssd_pkg;

	localparam int DIGITS_DEF      = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int VALUE_W   = 14;
	localparam int CODE_W    = 4;
	localparam int COMMON_W  = 4;
	localparam int SEG_W     = 8;

	// divide by ten: (x * 52429) >> 19 is exact for x below 2^16
	localparam int RECIP_W     = 16;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = VALUE_W + RECIP_W;
	localparam int QUO_W       = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP = 16'd52429;

	localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_LOAD = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [VALUE_W-1:0]  value;
	} in_t;

	typedef struct packed {
		logic [COMMON_W-1:0] common_drive;
		logic [SEG_W-1:0]    segment_drive;
	} out_t;

	// segments A..G on bits 0..6, DP off, blank above nine
	function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
		logic [SEG_W-1:0] s;
		case (code)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/core/seven_segment_scan_driver_unit.sv @@
// Top level of the multiplexed seven-segment scan driver.
// Usage:
//   Input queue (push/full/item): item.kind selects a scan tick or a load;
//   a load carries item.value, shown as its low DIGITS decimal digits with
//   the most significant digit on the first common. A transfer happens when
//   push is high and full is low.
//   Result queue (empty/pop/result): every item gives one result. A tick
//   gives the common lines (active low, one low) and segments A..G for the
//   current position, then steps the position. A load restarts the scan and
//   repeats the last common and segment values.
//   Path from input transfer to result: one divide-by-ten stage per digit,
//   then the digit queue and the result queue. Throughput: one item per
//   cycle while no queue is full.
//   Reset: all queues empty, digits blank, position at the first digit,
//   common and segment registers zero.
//   A stalled receiver fills the result queue, then the digit queue, then
//   the split pipeline; full rises and nothing is dropped.
`timescale 1ns / 1ps

module seven_segment_scan_driver_unit #(
	parameter int DIGITS      = sssd_pkg::DIGITS_DEF,
	parameter int QUEUE_DEPTH = sssd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  sssd_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output sssd_pkg::out_t result
);

	localparam int CMD_W = DIGITS * sssd_pkg::CODE_W + 1;
	localparam int RES_W = $bits(sssd_pkg::out_t);

	logic             cmd_push;
	logic             cmd_full;
	logic [CMD_W-1:0] cmd_in;
	logic [CMD_W-1:0] cmd_out;
	logic             cmd_empty;
	logic             cmd_pop;

	logic             res_push;
	logic             res_full;
	sssd_pkg::out_t   res_in;
	logic [RES_W-1:0] res_out;

	sssd_front #(.DIGITS(DIGITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd_data (cmd_in),
		.cmd_full (cmd_full)
	);

	sssd_fifo #(.W(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	sssd_back #(.DIGITS(DIGITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_data  (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	sssd_fifo #(.W(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign result = sssd_pkg::out_t'(res_out);

endmodule

@@ rtl/core/sssd_fifo.sv @@
// Small register-based queue with full and empty flags.
`timescale 1ns / 1ps

module sssd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = sssd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/sssd_front.sv @@
// Front end: accepts items and splits load values into decimal digits, one digit per stage.
`timescale 1ns / 1ps

module sssd_front #(
	parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  sssd_pkg::in_t                        item,
	output logic                                 cmd_push,
	output logic [DIGITS*sssd_pkg::CODE_W:0]     cmd_data,
	input  logic                                 cmd_full
);

	localparam int CW      = sssd_pkg::CODE_W;
	localparam int VW      = sssd_pkg::VALUE_W;
	localparam int CODES_W = DIGITS * CW;

	logic                 valid_s [DIGITS];
	sssd_pkg::kind_t      kind_s  [DIGITS];
	logic [VW-1:0]        rem_s   [DIGITS];
	logic [CODES_W-1:0]   codes_s [DIGITS];

	logic                 src_valid [DIGITS];
	sssd_pkg::kind_t      src_kind  [DIGITS];
	logic [VW-1:0]        src_rem   [DIGITS];
	logic [CODES_W-1:0]   src_codes [DIGITS];
	logic [CODES_W-1:0]   next_codes [DIGITS];
	logic [sssd_pkg::PROD_W-1:0] prod [DIGITS];
	logic [sssd_pkg::QUO_W-1:0]  quo  [DIGITS];
	logic [VW-1:0]        diff [DIGITS];

	logic adv;

	assign adv      = !(valid_s[DIGITS-1] && cmd_full);
	assign full     = !adv;
	assign cmd_push = valid_s[DIGITS-1] && adv;
	assign cmd_data = {kind_s[DIGITS-1], codes_s[DIGITS-1]};

	for (genvar k = 0; k < DIGITS; k++) begin : g_stage
		if (k == 0) begin : g_head
			assign src_valid[k] = push;
			assign src_kind[k]  = item.kind;
			assign src_rem[k]   = item.value;
			assign src_codes[k] = '0;
		end else begin : g_body
			assign src_valid[k] = valid_s[k-1];
			assign src_kind[k]  = kind_s[k-1];
			assign src_rem[k]   = rem_s[k-1];
			assign src_codes[k] = codes_s[k-1];
		end

		assign prod[k] = sssd_pkg::PROD_W'(src_rem[k]) * sssd_pkg::PROD_W'(sssd_pkg::RECIP);
		assign quo[k]  = prod[k][sssd_pkg::PROD_W-1:sssd_pkg::RECIP_SHIFT];
		assign diff[k] = src_rem[k] - (VW'({quo[k], 3'b000}) + VW'({quo[k], 1'b0}));

		// each stage fills its own digit slot, still zero from earlier stages
		assign next_codes[k] = src_codes[k] |
			(CODES_W'(diff[k][CW-1:0]) << ((DIGITS-1-k)*CW));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= src_valid[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				kind_s[k]  <= src_kind[k];
				rem_s[k]   <= VW'(quo[k]);
				codes_s[k] <= next_codes[k];
			end
		end
	end

endmodule

@@ rtl/core/sssd_back.sv @@
// Back end: digit store, scan position and display line registers.
`timescale 1ns / 1ps

module sssd_back #(
	parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_empty,
	input  logic [DIGITS*sssd_pkg::CODE_W:0] cmd_data,
	output logic                             cmd_pop,
	input  logic                             res_full,
	output logic                             res_push,
	output sssd_pkg::out_t                   res
);

	localparam int CW    = sssd_pkg::CODE_W;
	localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [CW-1:0]                 codes_q [DIGITS];
	logic [POS_W-1:0]              pos_q;
	logic [sssd_pkg::COMMON_W-1:0] common_q;
	logic [sssd_pkg::SEG_W-1:0]    segment_q;

	logic                          fire;
	sssd_pkg::kind_t               cmd_kind;
	logic [sssd_pkg::COMMON_W-1:0] tick_common;
	logic [sssd_pkg::SEG_W-1:0]    tick_seg;

	assign fire     = !cmd_empty && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;
	assign cmd_kind = sssd_pkg::kind_t'(cmd_data[DIGITS*CW]);
	assign tick_seg = sssd_pkg::seg_of(codes_q[pos_q]);

	always_comb begin
		for (int b = 0; b < sssd_pkg::COMMON_W; b++) begin
			tick_common[b] = (b < DIGITS) && (pos_q != POS_W'(b));
		end
	end

	always_comb begin
		if (cmd_kind == sssd_pkg::KIND_LOAD) begin
			res.common_drive  = common_q;
			res.segment_drive = segment_q;
		end else begin
			res.common_drive  = tick_common;
			res.segment_drive = tick_seg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				codes_q[i] <= sssd_pkg::CODE_BLANK;
			end
			pos_q     <= '0;
			common_q  <= '0;
			segment_q <= '0;
		end else if (fire) begin
			if (cmd_kind == sssd_pkg::KIND_LOAD) begin
				for (int i = 0; i < DIGITS; i++) begin
					codes_q[i] <= cmd_data[i*CW +: CW];
				end
				pos_q <= '0;
			end else begin
				common_q  <= tick_common;
				segment_q <= tick_seg;
				pos_q     <= (pos_q == POS_W'(DIGITS - 1)) ? '0 : pos_q + POS_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/sssd_checker.sv @@
// Port-level checker for the seven-segment scan driver, bound to the top level.
`timescale 1ns / 1ps
`include "seven_segment_scan_driver_unit_assert.svh"

module sssd_checker #(
	parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           push,
	input logic           full,
	input sssd_pkg::in_t  item,
	input logic           empty,
	input logic           pop,
	input sssd_pkg::out_t result
);

	localparam int LIVE = (DIGITS < sssd_pkg::COMMON_W) ? DIGITS : sssd_pkg::COMMON_W;

	logic ports_known;
	logic one_low;

	assign ports_known = !$isunknown({push, full, item, empty, pop});
	assign one_low     = (result.common_drive == '0) ||
		($countones(result.common_drive) == LIVE - 1);

	// handshake and item lines are driven
	`SSSD_ASSERT_IMPL(a_known, 1'b1, ports_known, "unknown handshake or item value")

	// DP never lit
	`SSSD_ASSERT_IMPL(a_dp_off, !empty, result.segment_drive[sssd_pkg::SEG_W-1] == 1'b0, "DP lit")

	// either all commons zero as after reset, or exactly one live common low
	`SSSD_ASSERT_IMPL(a_one_common, !empty, one_low, "bad common drive")

	// waiting result is not withdrawn
	`SSSD_ASSERT_NEXT(a_hold_valid, !empty && !pop, !empty, "result withdrawn")

	// waiting result holds its value
	`SSSD_ASSERT_NEXT(a_hold_data, !empty && !pop, $stable(result), "result changed while stalled")

endmodule

bind seven_segment_scan_driver_unit sssd_checker #(.DIGITS(DIGITS)) u_sssd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
